/* rtl/owdm_pkg.sv */
// Shared constants, register codes and arithmetic helpers for the omni wheel drive mixer.
package owdm_pkg;

    localparam int AxisW  = 9;
    localparam int CfgW   = 8;
    localparam int AddrW  = 4;
    localparam int DataW  = 32;
    localparam int CountW = 32;
    localparam int NumWheels = 4;

    // Widths through the datapath: negated axis, mixed sum, magnitude, product.
    localparam int NegW  = AxisW + 1;
    localparam int MixW  = AxisW + 2;
    localparam int MagW  = MixW - 1;
    localparam int ProdW = MagW + CfgW;
    localparam int QuotW = MagW;

    localparam logic [CfgW-1:0] DeadzoneRst = 8'd30;
    localparam logic [CfgW-1:0] DriveMinRst = 8'd100;
    localparam logic [CfgW-1:0] DriveMaxRst = 8'd255;

    // Wheel order FL, FR, BL, BR. A set bit means the axis enters that wheel negated.
    localparam logic [NumWheels-1:0] XNeg = 4'b0110;
    localparam logic [NumWheels-1:0] ZNeg = 4'b1010;

    typedef enum logic [1:0] {
        REG_DEADZONE  = 2'd0,
        REG_DRIVE_MIN = 2'd1,
        REG_DRIVE_MAX = 2'd2,
        REG_NONE      = 2'd3
    } t_reg_idx;

    // Zero an axis whose magnitude lies strictly below the deadzone.
    function automatic logic signed [NegW-1:0] apply_deadzone(
        input logic signed [NegW-1:0] a,
        input logic [CfgW-1:0]        dz
    );
        logic [NegW-1:0] mag;
        mag = a[NegW-1] ? NegW'(-a) : NegW'(a);
        return (mag < {2'b00, dz}) ? '0 : a;
    endfunction

    // Exact floor(p / 255) for p below 2^18: multiply by 263173, which is
    // ceil(2^26 / 255) = 2^18 + 2^10 + 2^2 + 1, and keep bits 26 and up.
    function automatic logic [QuotW-1:0] div255(input logic [ProdW-1:0] p);
        logic [44:0] w;
        logic [44:0] acc;
        w   = {27'd0, p};
        acc = (w << 18) + (w << 10) + (w << 2) + w;
        return acc[26 +: QuotW];
    endfunction

endpackage

/* rtl/omni_wheel_drive_mixer.sv */
// Omni wheel drive mixer: deadzone, four wheel mixing, drive remapping and power latch.
// Throughput: one transaction per cycle unless stalled; the three pipeline registers
// form an elastic chain and each stage takes new data whenever its successor has room.
// The scaling multiply and the divide by 255 sit in separate stages.
// Synchronous active-low reset empties the pipeline, clears the power latch and the
// message counter, and returns deadzone, drive_min and drive_max to 30, 100 and 255.
module omni_wheel_drive_mixer
    import owdm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [AddrW-1:0]         paddr,
    input  logic [DataW-1:0]         pwdata,
    output logic [DataW-1:0]         prdata,
    output logic                     pready,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_pad_present,
    input  logic signed [AxisW-1:0]  i_left_y,
    input  logic signed [AxisW-1:0]  i_left_x,
    input  logic signed [AxisW-1:0]  i_right_x,
    input  logic                     i_start_pressed,
    input  logic                     i_stop_pressed,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [AxisW-1:0]  o_front_left,
    output logic signed [AxisW-1:0]  o_front_right,
    output logic signed [AxisW-1:0]  o_back_left,
    output logic signed [AxisW-1:0]  o_back_right,
    output logic                     o_power_on,
    output logic [CountW-1:0]        o_message_number
);

    logic [CfgW-1:0] r_deadzone, r_drive_min, r_drive_max;
    logic            cfg_write;
    t_reg_idx        cfg_idx;

    logic              r_power, n_power;
    logic [CountW-1:0] r_count, n_count;
    logic              in_accept;
    logic              rdy1, rdy2, rdy3;

    // Stage 1: registered inputs.
    logic                    r_s1_valid;
    logic                    r_s1_pad;
    logic signed [AxisW-1:0] r_s1_ly, r_s1_lx, r_s1_rx;
    logic                    r_s1_power;
    logic [CountW-1:0]       r_s1_count;

    // Stage 2: scaled magnitudes before the divide.
    logic                    r_s2_valid;
    logic [ProdW-1:0]        r_s2_prod [NumWheels];
    logic [NumWheels-1:0]    r_s2_neg, r_s2_zero;
    logic                    r_s2_power;
    logic [CountW-1:0]       r_s2_count;

    // Stage 3: result register.
    logic                    r_s3_valid;
    logic signed [AxisW-1:0] r_s3_wheel [NumWheels];
    logic                    r_s3_power;
    logic [CountW-1:0]       r_s3_count;

    logic [ProdW-1:0]        n_s2_prod [NumWheels];
    logic [NumWheels-1:0]    n_s2_neg, n_s2_zero;
    logic signed [AxisW-1:0] n_s3_wheel [NumWheels];

    // ---------------- Configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_idx   = t_reg_idx'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        case (cfg_idx)
            REG_DEADZONE:  prdata = {{(DataW-CfgW){1'b0}}, r_deadzone};
            REG_DRIVE_MIN: prdata = {{(DataW-CfgW){1'b0}}, r_drive_min};
            REG_DRIVE_MAX: prdata = {{(DataW-CfgW){1'b0}}, r_drive_max};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone  <= DeadzoneRst;
            r_drive_min <= DriveMinRst;
            r_drive_max <= DriveMaxRst;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_DEADZONE:  r_deadzone  <= pwdata[CfgW-1:0];
                REG_DRIVE_MIN: r_drive_min <= pwdata[CfgW-1:0];
                REG_DRIVE_MAX: r_drive_max <= pwdata[CfgW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- Pipeline flow control ----------------
    assign rdy3       = !r_s3_valid || i_out_ready;
    assign rdy2       = !r_s2_valid || rdy3;
    assign rdy1       = !r_s1_valid || rdy2;
    assign o_in_ready = rdy1;
    assign in_accept  = i_in_valid && rdy1;

    // The latch and counter advance in transaction order at acceptance.
    always_comb begin
        n_count = r_count + CountW'(1);
        if (!i_pad_present) begin
            n_power = 1'b0;
        end else begin
            n_power = (r_power || i_start_pressed) && !i_stop_pressed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power <= 1'b0;
            r_count <= '0;
        end else if (in_accept) begin
            r_power <= n_power;
            r_count <= n_count;
        end
    end

    // ---------------- Stage 1 -> 2: deadzone, mixing, scaling ----------------
    always_comb begin
        logic signed [NegW-1:0] y, x, z;
        logic signed [MixW-1:0] sx, sz, mix;
        logic [MagW-1:0]        mag;
        logic [CfgW-1:0]        span;
        y    = apply_deadzone(-NegW'(r_s1_ly), r_deadzone);
        x    = apply_deadzone(NegW'(r_s1_lx), r_deadzone);
        z    = apply_deadzone(NegW'(r_s1_rx), r_deadzone);
        span = (r_drive_max >= r_drive_min) ? (r_drive_max - r_drive_min) : '0;
        for (int w = 0; w < NumWheels; w++) begin
            sx  = XNeg[w] ? -MixW'(x) : MixW'(x);
            sz  = ZNeg[w] ? -MixW'(z) : MixW'(z);
            mix = MixW'(y) + sx + sz;
            mag = mix[MixW-1] ? MagW'(-mix) : MagW'(mix);
            n_s2_prod[w] = ProdW'(mag) * ProdW'(span);
            n_s2_neg[w]  = mix[MixW-1];
            n_s2_zero[w] = (mix == '0) || !r_s1_pad;
        end
    end

    // ---------------- Stage 2 -> 3: divide, offset, clamp, sign ----------------
    always_comb begin
        logic [QuotW-1:0] q;
        logic [QuotW:0]   sum;
        logic [CfgW-1:0]  drv;
        for (int w = 0; w < NumWheels; w++) begin
            q   = div255(r_s2_prod[w]);
            sum = {{(QuotW+1-CfgW){1'b0}}, r_drive_min} + {1'b0, q};
            drv = (sum > {{(QuotW+1-CfgW){1'b0}}, r_drive_max}) ? r_drive_max : sum[CfgW-1:0];
            if (r_s2_zero[w]) begin
                n_s3_wheel[w] = '0;
            end else if (r_s2_neg[w]) begin
                n_s3_wheel[w] = -$signed({1'b0, drv});
            end else begin
                n_s3_wheel[w] = $signed({1'b0, drv});
            end
        end
    end

    // ---------------- Pipeline registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (rdy1) begin
                r_s1_valid <= i_in_valid;
            end
            if (rdy2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (rdy3) begin
                r_s3_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_pad   <= i_pad_present;
            r_s1_ly    <= i_left_y;
            r_s1_lx    <= i_left_x;
            r_s1_rx    <= i_right_x;
            r_s1_power <= n_power;
            r_s1_count <= n_count;
        end
        if (r_s1_valid && rdy2) begin
            r_s2_prod  <= n_s2_prod;
            r_s2_neg   <= n_s2_neg;
            r_s2_zero  <= n_s2_zero;
            r_s2_power <= r_s1_power;
            r_s2_count <= r_s1_count;
        end
        if (r_s2_valid && rdy3) begin
            r_s3_wheel <= n_s3_wheel;
            r_s3_power <= r_s2_power;
            r_s3_count <= r_s2_count;
        end
    end

    assign o_out_valid      = r_s3_valid;
    assign o_front_left     = r_s3_wheel[0];
    assign o_front_right    = r_s3_wheel[1];
    assign o_back_left      = r_s3_wheel[2];
    assign o_back_right     = r_s3_wheel[3];
    assign o_power_on       = r_s3_power;
    assign o_message_number = r_s3_count;

    // ---------------- Assertions ----------------
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && in_accept) |=> (r_count == $past(r_count) + CountW'(1)))
        else $error("message counter did not advance by one on an accepted transaction");

    a_absent_pad_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && in_accept && !i_pad_present) |=> (!r_power && !r_s1_power))
        else $error("power latch not cleared for a transaction without a controller");

    a_stop_wins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && in_accept && i_stop_pressed) |=> !r_power)
        else $error("stop press did not clear the power latch");

    a_s2_to_s3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && r_s2_valid && rdy3) |=> r_s3_valid)
        else $error("stage 2 data moved on but no result became valid");

    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && r_s2_valid && !rdy3) |=> (r_s2_valid && $stable(r_s2_count)))
        else $error("stalled stage 2 data was lost or changed");

endmodule

/* tb/sv/omni_wheel_drive_mixer_tb.sv */
// Self-checking testbench for the omni wheel drive mixer: register setup, tick stimulus, drive checks.
`timescale 1ns / 100ps

module omni_wheel_drive_mixer_tb;
    import owdm_pkg::*;

    localparam int CycleLimit = 300000;
    localparam int ReportMax  = 10;

    typedef struct packed {
        logic                    pad;
        logic signed [AxisW-1:0] ly;
        logic signed [AxisW-1:0] lx;
        logic signed [AxisW-1:0] rx;
        logic                    start;
        logic                    stop;
    } t_tick;

    typedef struct packed {
        logic signed [AxisW-1:0] fl;
        logic signed [AxisW-1:0] fr;
        logic signed [AxisW-1:0] bl;
        logic signed [AxisW-1:0] br;
        logic                    power;
        logic [CountW-1:0]       msg;
    } t_drive;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [AddrW-1:0]        paddr = '0;
    logic [DataW-1:0]        pwdata = '0;
    logic [DataW-1:0]        prdata;
    logic                    pready;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic                    i_pad_present = 1'b0;
    logic signed [AxisW-1:0] i_left_y = '0;
    logic signed [AxisW-1:0] i_left_x = '0;
    logic signed [AxisW-1:0] i_right_x = '0;
    logic                    i_start_pressed = 1'b0;
    logic                    i_stop_pressed = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic signed [AxisW-1:0] o_front_left;
    logic signed [AxisW-1:0] o_front_right;
    logic signed [AxisW-1:0] o_back_left;
    logic signed [AxisW-1:0] o_back_right;
    logic                    o_power_on;
    logic [CountW-1:0]       o_message_number;

    omni_wheel_drive_mixer u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_pad_present    (i_pad_present),
        .i_left_y         (i_left_y),
        .i_left_x         (i_left_x),
        .i_right_x        (i_right_x),
        .i_start_pressed  (i_start_pressed),
        .i_stop_pressed   (i_stop_pressed),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_front_left     (o_front_left),
        .o_front_right    (o_front_right),
        .o_back_left      (o_back_left),
        .o_back_right     (o_back_right),
        .o_power_on       (o_power_on),
        .o_message_number (o_message_number)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Mirror of the block's configuration and state.
    int                cfg_deadzone = 30;
    int                cfg_drive_min = 100;
    int                cfg_drive_max = 255;
    logic              motor_latch = 1'b0;
    logic [CountW-1:0] tick_total = '0;

    t_tick  ticks_to_send[$];
    t_drive drives_due[$];
    t_tick  tick_on_bus;
    int     send_idle = 0;
    int     recv_idle = 0;
    int     mismatches = 0;
    int     cycles = 0;

    function automatic int axis_gate(input int a);
        int mag;
        mag = (a < 0) ? -a : a;
        return (mag < cfg_deadzone) ? 0 : a;
    endfunction

    function automatic logic signed [AxisW-1:0] wheel_drive(input int v);
        int mag;
        int span;
        int level;
        mag = (v < 0) ? -v : v;
        if (mag == 0) begin
            return '0;
        end
        span  = (cfg_drive_max >= cfg_drive_min) ? cfg_drive_max - cfg_drive_min : 0;
        level = cfg_drive_min + (mag * span) / 255;
        if (level > cfg_drive_max) begin
            level = cfg_drive_max;
        end
        if (v < 0) begin
            level = -level;
        end
        return AxisW'(level);
    endfunction

    task automatic predict_drive(input t_tick t);
        t_drive d;
        int     y;
        int     x;
        int     z;
        tick_total = tick_total + 1'b1;
        if (t.pad) begin
            // The forward axis is inverted before the deadzone, so an up stick drives forward.
            y = axis_gate(-int'(t.ly));
            x = axis_gate(int'(t.lx));
            z = axis_gate(int'(t.rx));
            d.fl = wheel_drive(y + x + z);
            d.fr = wheel_drive(y - x - z);
            d.bl = wheel_drive(y - x + z);
            d.br = wheel_drive(y + x - z);
            if (t.start) begin
                motor_latch = 1'b1;
            end
            if (t.stop) begin
                motor_latch = 1'b0;
            end
        end else begin
            d.fl = '0;
            d.fr = '0;
            d.bl = '0;
            d.br = '0;
            motor_latch = 1'b0;
        end
        d.power = motor_latch;
        d.msg   = tick_total;
        drives_due.insert(drives_due.size(), d);
    endtask

    // Driver: a new tick is offered only once the previous one has been accepted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predict_drive(tick_on_bus);
            end
            if (!i_in_valid || o_in_ready) begin
                if (ticks_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                    tick_on_bus = ticks_to_send.pop_front();
                    i_in_valid      <= 1'b1;
                    i_pad_present   <= tick_on_bus.pad;
                    i_left_y        <= tick_on_bus.ly;
                    i_left_x        <= tick_on_bus.lx;
                    i_right_x       <= tick_on_bus.rx;
                    i_start_pressed <= tick_on_bus.start;
                    i_stop_pressed  <= tick_on_bus.stop;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each drive transaction against the oldest prediction.
    always @(posedge i_clk) begin
        t_drive got;
        t_drive want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = '{o_front_left, o_front_right, o_back_left, o_back_right,
                        o_power_on, o_message_number};
                if (drives_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= ReportMax) begin
                        $display("unexpected drive: fl %0d fr %0d bl %0d br %0d pwr %0b msg %0d",
                                 got.fl, got.fr, got.bl, got.br, got.power, got.msg);
                    end
                end else begin
                    want = drives_due.pop_front();
                    if (got.fl !== want.fl || got.fr !== want.fr || got.bl !== want.bl ||
                        got.br !== want.br || got.power !== want.power ||
                        got.msg !== want.msg) begin
                        mismatches++;
                        if (mismatches <= ReportMax) begin
                            $display("drive wrong: exp fl %0d fr %0d bl %0d br %0d pwr %0b msg %0d",
                                     want.fl, want.fr, want.bl, want.br, want.power, want.msg);
                            $display("             got fl %0d fr %0d bl %0d br %0d pwr %0b msg %0d",
                                     got.fl, got.fr, got.bl, got.br, got.power, got.msg);
                        end
                    end
                end
            end
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("omni_wheel_drive_mixer: mismatch");
            $finish;
        end
    end

    task automatic write_reg(input t_reg_idx idx, input int val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrW'({idx, 2'b00});
        pwdata  <= DataW'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DEADZONE:  cfg_deadzone  = val;
            REG_DRIVE_MIN: cfg_drive_min = val;
            REG_DRIVE_MAX: cfg_drive_max = val;
            default: ;
        endcase
    endtask

    task automatic push_tick(input logic pad, input int ly, input int lx, input int rx,
                             input logic start, input logic stop);
        t_tick t;
        t.pad   = pad;
        t.ly    = AxisW'(ly);
        t.lx    = AxisW'(lx);
        t.rx    = AxisW'(rx);
        t.start = start;
        t.stop  = stop;
        ticks_to_send.insert(ticks_to_send.size(), t);
    endtask

    // Axis values lean towards the deadzone edges and the extremes of the range.
    function automatic int rand_axis();
        int sgn;
        sgn = $urandom_range(0, 1) ? -1 : 1;
        case ($urandom_range(0, 9))
            0: return 0;
            1: return sgn * cfg_deadzone;
            2: return sgn * (cfg_deadzone > 0 ? cfg_deadzone - 1 : 0);
            3: return -256;
            4: return sgn * 255;
            5: return sgn * int'($urandom_range(0, 40));
            default: return int'($urandom_range(0, 511)) - 256;
        endcase
    endfunction

    task automatic push_random(input int n);
        repeat (n) begin
            push_tick($urandom_range(0, 9) != 0, rand_axis(), rand_axis(), rand_axis(),
                      $urandom_range(0, 4) == 0, $urandom_range(0, 6) == 0);
        end
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (ticks_to_send.size() != 0 || i_in_valid || drives_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic run_phase(input int dz, input int dmin, input int dmax,
                             input int s_idle, input int r_idle, input int n,
                             input bit pause_midway);
        write_reg(REG_DEADZONE, dz);
        write_reg(REG_DRIVE_MIN, dmin);
        write_reg(REG_DRIVE_MAX, dmax);
        send_idle = s_idle;
        recv_idle = r_idle;
        if (pause_midway) begin
            push_random(n / 2);
            wait_drained();
            push_random(n - n / 2);
        end else begin
            push_random(n);
        end
        wait_drained();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle = 27;
        recv_idle = 62;

        // Directed ticks under the reset configuration.
        push_tick(1, 0, 0, 0, 0, 0);
        push_tick(1, -256, -256, -256, 1, 0);
        push_tick(1, 255, 255, 255, 0, 0);
        push_tick(1, -255, 255, -255, 0, 0);
        push_tick(1, 255, -255, 255, 0, 1);
        push_tick(1, -29, 29, -29, 1, 0);
        push_tick(1, -30, 30, 30, 0, 0);
        // Strafe cancels forward on two wheels, giving a zero mix there.
        push_tick(1, -100, -100, 0, 0, 0);
        push_tick(1, -1, 1, -1, 1, 1);
        push_tick(1, 0, 0, -256, 1, 0);
        push_tick(0, -200, 200, 100, 1, 0);
        push_tick(1, -128, 64, 0, 1, 0);
        push_tick(0, 0, 0, 0, 0, 1);
        push_tick(1, -256, 255, -256, 1, 0);
        push_tick(1, -256, -255, -256, 0, 0);
        push_tick(1, 255, 0, 0, 0, 0);
        push_tick(1, 0, -31, 31, 1, 0);
        push_tick(1, 0, 0, 0, 1, 1);
        push_tick(1, 170, -85, -42, 0, 0);
        push_tick(1, -50, 0, 0, 1, 0);
        push_tick(1, -50, 0, 0, 0, 0);
        wait_drained();

        run_phase(0, 0, 255, 27, 62, 140, 1'b0);
        run_phase(255, 255, 255, 27, 62, 130, 1'b0);
        // drive_min above drive_max collapses the span to nothing.
        run_phase(40, 200, 60, 62, 27, 130, 1'b1);
        run_phase($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                  62, 27, 160, 1'b0);
        run_phase(30, 100, 255, 0, 0, 140, 1'b0);
        run_phase(10, 0, 0, 0, 0, 120, 1'b0);

        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && drives_due.size() == 0) begin
            $display("omni_wheel_drive_mixer: match");
        end else begin
            $display("omni_wheel_drive_mixer: mismatch");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/owdm_pkg.sv
rtl/omni_wheel_drive_mixer.sv
tb/sv/omni_wheel_drive_mixer_tb.sv
